[design/sict_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sict_pkg: shared types and constants of the shift ignition cut timer
// Command codes, register map, reset values, payload, result, config and state records.
// ----------------------------------------------------------------------------
package sict_pkg;

	localparam int unsigned AddrWidth = 4;
	localparam int unsigned DataWidth = 32;

	typedef enum logic [1:0] {
		CMD_CRANK = 2'd0,
		CMD_TIME  = 2'd1,
		CMD_STOP  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_CUT_ENABLE = 2'd0,
		REG_CUT_LENGTH = 2'd1,
		REG_ARM_RPM    = 2'd2,
		REG_DEAD_TIME  = 2'd3
	} reg_idx_t;

	localparam logic        CutEnableRst = 1'b1;
	localparam logic [15:0] CutLengthRst = 16'd50;
	localparam logic [15:0] ArmRpmRst    = 16'd3000;
	localparam logic [15:0] DeadTimeRst  = 16'd500;

	typedef struct packed {
		logic [1:0]  command;
		logic        switch_pressed;
		logic [15:0] engine_rpm;
		logic [31:0] now_ms;
	} item_t;

	typedef struct packed {
		logic ign_cut;
		logic lockout_active;
		logic armed_status;
	} result_t;

	typedef struct packed {
		logic        cut_enable;
		logic [15:0] cut_length_ms;
		logic [15:0] arm_rpm;
		logic [15:0] dead_time_ms;
	} cfg_t;

	typedef struct packed {
		logic        armed;
		logic        pending;
		logic        cutting;
		logic        locked;
		logic [31:0] start;
	} state_t;

endpackage
`default_nettype wire

[design/sict_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sict_regs: configuration register file
// APB-style write and read of the four control registers.
// ----------------------------------------------------------------------------
module sict_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [sict_pkg::AddrWidth-1:0]   paddr,
	input  wire logic [sict_pkg::DataWidth-1:0]   pwdata,
	output logic      [sict_pkg::DataWidth-1:0]   prdata,
	output logic                                  pready,
	output sict_pkg::cfg_t                        cfg
);

	sict_pkg::cfg_t    cfg_q;
	sict_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = sict_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cut_enable    <= sict_pkg::CutEnableRst;
			cfg_q.cut_length_ms <= sict_pkg::CutLengthRst;
			cfg_q.arm_rpm       <= sict_pkg::ArmRpmRst;
			cfg_q.dead_time_ms  <= sict_pkg::DeadTimeRst;
		end else if (wr_en) begin
			unique case (idx)
				sict_pkg::REG_CUT_ENABLE: cfg_q.cut_enable    <= pwdata[0];
				sict_pkg::REG_CUT_LENGTH: cfg_q.cut_length_ms <= pwdata[15:0];
				sict_pkg::REG_ARM_RPM:    cfg_q.arm_rpm       <= pwdata[15:0];
				sict_pkg::REG_DEAD_TIME:  cfg_q.dead_time_ms  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			sict_pkg::REG_CUT_ENABLE: prdata = {31'd0, cfg_q.cut_enable};
			sict_pkg::REG_CUT_LENGTH: prdata = {16'd0, cfg_q.cut_length_ms};
			sict_pkg::REG_ARM_RPM:    prdata = {16'd0, cfg_q.arm_rpm};
			sict_pkg::REG_DEAD_TIME:  prdata = {16'd0, cfg_q.dead_time_ms};
			default:                  prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

[design/sict_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sict_core: trigger, cut and lockout state
// Applies one word to the state when enabled and forms its result combinationally.
// ----------------------------------------------------------------------------
module sict_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire sict_pkg::item_t      word,
	input  wire sict_pkg::cfg_t       cfg,
	output sict_pkg::result_t         res
);

	sict_pkg::state_t state_q;
	sict_pkg::state_t nxt;
	sict_pkg::cmd_t   cmd;
	logic [31:0]      elapsed;

	assign cmd = sict_pkg::cmd_t'(word.command);

	always_comb begin
		nxt     = state_q;
		elapsed = '0;
		unique case (cmd)
			sict_pkg::CMD_CRANK: begin
				if (cfg.cut_enable) begin
					if (!word.switch_pressed) begin
						nxt.armed = 1'b1;
					end else if (state_q.armed && !state_q.locked &&
							word.engine_rpm >= cfg.arm_rpm) begin
						nxt.armed   = 1'b0;
						nxt.pending = 1'b1;
					end
				end
			end
			sict_pkg::CMD_TIME: begin
				nxt.pending = 1'b0;
				if (state_q.pending && !state_q.cutting && !state_q.locked) begin
					nxt.start   = word.now_ms;
					nxt.cutting = 1'b1;
					nxt.locked  = 1'b1;
				end
				elapsed = word.now_ms - nxt.start;
				if (nxt.cutting && elapsed >= {16'd0, cfg.cut_length_ms})
					nxt.cutting = 1'b0;
				if (nxt.locked && elapsed >= {16'd0, cfg.dead_time_ms})
					nxt.locked = 1'b0;
			end
			sict_pkg::CMD_STOP: begin
				nxt.cutting = 1'b0;
				nxt.pending = 1'b0;
				nxt.locked  = 1'b0;
				nxt.armed   = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.armed   <= 1'b1;
			state_q.pending <= 1'b0;
			state_q.cutting <= 1'b0;
			state_q.locked  <= 1'b0;
			state_q.start   <= '0;
		end else if (en) begin
			state_q <= nxt;
		end
	end

	assign res.ign_cut        = nxt.cutting;
	assign res.lockout_active = nxt.locked;
	assign res.armed_status   = nxt.armed;

endmodule
`default_nettype wire

[design/shift_ignition_cut_timer.sv]
`default_nettype none
// The accepted word is registered in word_s1, its result then in result_q.
// Throughput: one word per cycle; the input register, the state update and the
// output register form a two-stage pipeline that stalls only on result_ready.
// Reset (arst_n low, asynchronous): pipeline empty, state armed with no cut,
// lockout or pending trigger, registers at their defaults.
// ----------------------------------------------------------------------------
// shift_ignition_cut_timer: ignition cut timer for clutchless shifting
// Input register, state update, output register, APB registers.
// ----------------------------------------------------------------------------
module shift_ignition_cut_timer (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             item_valid,
	output logic                                  item_ready,
	input  wire sict_pkg::item_t                  item,
	output logic                                  result_valid,
	input  wire logic                             result_ready,
	output sict_pkg::result_t                     result,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [sict_pkg::AddrWidth-1:0]   paddr,
	input  wire logic [sict_pkg::DataWidth-1:0]   pwdata,
	output logic      [sict_pkg::DataWidth-1:0]   prdata,
	output logic                                  pready
);

	sict_pkg::cfg_t    cfg;
	sict_pkg::item_t   word_s1;
	logic              valid_s1;
	logic              adv;
	sict_pkg::result_t res;
	sict_pkg::result_t result_q;
	logic              result_valid_q;

	sict_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign adv        = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid)
			word_s1 <= item;
	end

	sict_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.word   (word_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			result_q <= res;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

[design/sict_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sict_checker: port-level checks of the shift ignition cut timer
// Result hold, backpressure and result timing, bound to the top level.
// ----------------------------------------------------------------------------
module sict_checker (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   item_valid,
	input wire logic                   item_ready,
	input wire logic                   result_valid,
	input wire logic                   result_ready,
	input wire sict_pkg::result_t      result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> result_valid && !result_ready)
		else $error("input stalled without a stalled result");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && item_ready, 2))
		else $error("result appeared without a word accepted two edges before");

endmodule

bind shift_ignition_cut_timer sict_checker u_sict_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
`default_nettype wire

[test/tb_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the shift ignition cut timer
// Sends crank, time, stop and unused-code words through the valid/ready input
// and predicts the cut, lockout and armed flags of every word. Each result
// word is compared in order with its prediction. The run covers several
// register settings, random idling on both sides and one long result stall.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int WatchdogLimit = 2000;

	logic                           clk          = 1'b0;
	logic                           arst_n       = 1'b0;
	logic                           item_valid   = 1'b0;
	logic                           item_ready;
	sict_pkg::item_t                item         = '0;
	logic                           result_valid;
	logic                           result_ready = 1'b0;
	sict_pkg::result_t              result;
	logic                           psel         = 1'b0;
	logic                           penable      = 1'b0;
	logic                           pwrite       = 1'b0;
	logic [sict_pkg::AddrWidth-1:0] paddr        = '0;
	logic [sict_pkg::DataWidth-1:0] pwdata       = '0;
	logic [sict_pkg::DataWidth-1:0] prdata;
	logic                           pready;

	sict_pkg::cfg_t    timer_cfg;
	sict_pkg::state_t  timer_st;
	sict_pkg::result_t flags_due[$];
	sict_pkg::result_t flags_exp;
	logic [31:0]       clock_ms;
	int                send_idle_pct = 0;
	int                recv_idle_pct = 0;
	logic              hold_results  = 1'b0;
	int                idle_cycles   = 0;
	int                mismatches    = 0;
	int                words_sent    = 0;
	int                words_checked = 0;
	int                settings_used = 0;

	shift_ignition_cut_timer DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always #6 clk = ~clk;

	function automatic sict_pkg::result_t next_flags(sict_pkg::item_t w);
		logic [31:0]       elapsed;
		sict_pkg::result_t r;
		case (w.command)
		sict_pkg::CMD_CRANK: begin
			if (timer_cfg.cut_enable) begin
				if (!w.switch_pressed) begin
					timer_st.armed = 1'b1;
				end else if (timer_st.armed && !timer_st.locked &&
						w.engine_rpm >= timer_cfg.arm_rpm) begin
					timer_st.armed   = 1'b0;
					timer_st.pending = 1'b1;
				end
			end
		end
		sict_pkg::CMD_TIME: begin
			if (timer_st.pending) begin
				timer_st.pending = 1'b0;
				if (!timer_st.cutting && !timer_st.locked) begin
					timer_st.start   = w.now_ms;
					timer_st.cutting = 1'b1;
					timer_st.locked  = 1'b1;
				end
			end
			// elapsed time wraps modulo 2^32
			elapsed = w.now_ms - timer_st.start;
			if (elapsed >= {16'd0, timer_cfg.cut_length_ms}) begin
				timer_st.cutting = 1'b0;
			end
			if (elapsed >= {16'd0, timer_cfg.dead_time_ms}) begin
				timer_st.locked = 1'b0;
			end
		end
		sict_pkg::CMD_STOP: begin
			timer_st.cutting = 1'b0;
			timer_st.pending = 1'b0;
			timer_st.locked  = 1'b0;
			timer_st.armed   = 1'b1;
		end
		default: begin
		end
		endcase
		r.ign_cut        = timer_st.cutting;
		r.lockout_active = timer_st.locked;
		r.armed_status   = timer_st.armed;
		return r;
	endfunction

	task automatic check_field(string name, logic exp_bit, logic got_bit);
		if (got_bit !== exp_bit) begin
			$display("%0t: %s mismatch: expected %b, got %b", $time, name, exp_bit, got_bit);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		result_ready <= !hold_results && ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (idle_cycles >= WatchdogLimit) begin
				$display("%0t: no word moved for %0d cycles", $time, WatchdogLimit);
				$display("tb_top: FAIL");
				$finish;
			end else begin
				if ((item_valid && item_ready) || (result_valid && result_ready)) begin
					idle_cycles <= 0;
				end else begin
					idle_cycles <= idle_cycles + 1;
				end
				if (result_valid && result_ready) begin
					if (flags_due.size() == 0) begin
						$display("%0t: unexpected result word: expected none, got %b",
							$time, result);
						mismatches++;
					end else begin
						flags_exp = flags_due.pop_front();
						check_field("ign_cut", flags_exp.ign_cut, result.ign_cut);
						check_field("lockout_active", flags_exp.lockout_active,
							result.lockout_active);
						check_field("armed_status", flags_exp.armed_status,
							result.armed_status);
						words_checked++;
					end
				end
				if (item_valid && item_ready) begin
					flags_due.push_back(next_flags(item));
					words_sent++;
				end
			end
		end
	end

	task automatic set_idling(int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct <= recv_pct;
	endtask

	task automatic send_word(sict_pkg::item_t w);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item_valid <= 1'b1;
		item       <= w;
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		while (flags_due.size() != 0) @(posedge clk);
	endtask

	// write, then read back through the same port
	task automatic reg_write(sict_pkg::reg_idx_t idx, logic [31:0] value);
		logic [31:0] kept;
		case (idx)
		sict_pkg::REG_CUT_ENABLE: begin
			timer_cfg.cut_enable = value[0];
			kept = {31'd0, value[0]};
		end
		sict_pkg::REG_CUT_LENGTH: begin
			timer_cfg.cut_length_ms = value[15:0];
			kept = {16'd0, value[15:0]};
		end
		sict_pkg::REG_ARM_RPM: begin
			timer_cfg.arm_rpm = value[15:0];
			kept = {16'd0, value[15:0]};
		end
		default: begin
			timer_cfg.dead_time_ms = value[15:0];
			kept = {16'd0, value[15:0]};
		end
		endcase
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== kept) begin
			$display("%0t: register %s readback mismatch: expected %h, got %h",
				$time, idx.name(), kept, prdata);
			mismatches++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(logic en, logic [15:0] len, logic [15:0] rpm,
			logic [15:0] dead);
		drain_results();
		reg_write(sict_pkg::REG_CUT_ENABLE, {31'd0, en});
		reg_write(sict_pkg::REG_CUT_LENGTH, {16'd0, len});
		reg_write(sict_pkg::REG_ARM_RPM, {16'd0, rpm});
		reg_write(sict_pkg::REG_DEAD_TIME, {16'd0, dead});
		settings_used++;
	endtask

	function automatic sict_pkg::item_t mk_word(sict_pkg::cmd_t c, logic sw,
			logic [15:0] rpm, logic [31:0] now);
		sict_pkg::item_t w;
		w.command        = c;
		w.switch_pressed = sw;
		w.engine_rpm     = rpm;
		w.now_ms         = now;
		return w;
	endfunction

	// mostly crank/time traffic around the arm speed and the window lengths
	function automatic sict_pkg::item_t random_shift_word();
		sict_pkg::item_t w;
		int unsigned     pick;
		int unsigned     span;
		int              rpm;
		w.command        = sict_pkg::CMD_NONE;
		w.switch_pressed = 1'($urandom_range(1));
		w.engine_rpm     = 16'($urandom);
		w.now_ms         = $urandom;
		span = ((timer_cfg.cut_length_ms > timer_cfg.dead_time_ms) ?
			timer_cfg.cut_length_ms : timer_cfg.dead_time_ms) / 8 + 2;
		pick = $urandom_range(99);
		if (pick < 45) begin
			w.command        = sict_pkg::CMD_CRANK;
			w.switch_pressed = ($urandom_range(99) < 60);
			if ($urandom_range(3) != 0) begin
				rpm = int'(timer_cfg.arm_rpm) + int'($urandom_range(8)) - 4;
				w.engine_rpm = (rpm < 0) ? 16'd0 : (rpm > 65535) ? 16'hFFFF : 16'(rpm);
			end
		end else if (pick < 90) begin
			w.command = sict_pkg::CMD_TIME;
			if ($urandom_range(31) == 0) begin
				clock_ms = $urandom;
			end else begin
				clock_ms = clock_ms + $urandom_range(span);
			end
			w.now_ms = clock_ms;
		end else if (pick < 96) begin
			w.command = sict_pkg::CMD_STOP;
		end
		return w;
	endfunction

	task automatic random_phase(logic en, logic [15:0] len, logic [15:0] rpm,
			logic [15:0] dead, int count);
		apply_settings(en, len, rpm, dead);
		clock_ms = ($urandom_range(3) == 0) ? 32'hFFFF_FF00 : $urandom;
		repeat (count) send_word(random_shift_word());
	endtask

	task automatic stall_results(int cycles);
		hold_results <= 1'b1;
		repeat (cycles) @(posedge clk);
		hold_results <= 1'b0;
	endtask

	task automatic test_registers();
		reg_write(sict_pkg::REG_CUT_ENABLE, 32'hFFFF_FFFF);
		reg_write(sict_pkg::REG_CUT_LENGTH, 32'hFFFF_FFFF);
		reg_write(sict_pkg::REG_ARM_RPM, 32'hFFFF_FFFF);
		reg_write(sict_pkg::REG_DEAD_TIME, 32'hFFFF_FFFF);
		reg_write(sict_pkg::REG_CUT_ENABLE, 32'd0);
		reg_write(sict_pkg::REG_CUT_LENGTH, 32'd0);
		reg_write(sict_pkg::REG_ARM_RPM, 32'd0);
		reg_write(sict_pkg::REG_DEAD_TIME, 32'd0);
	endtask

	task automatic test_directed();
		apply_settings(sict_pkg::CutEnableRst, sict_pkg::CutLengthRst, sict_pkg::ArmRpmRst,
			sict_pkg::DeadTimeRst);
		send_word(mk_word(sict_pkg::CMD_NONE, 1'b1, 16'hFFFF, 32'hFFFF_FFFF));
		send_word(mk_word(sict_pkg::CMD_CRANK, 1'b1, 16'd2999, 32'hFFFF_FFFF));
		send_word(mk_word(sict_pkg::CMD_CRANK, 1'b1, 16'd3000, 32'h0));
		// cut starts just below the wrap point
		send_word(mk_word(sict_pkg::CMD_TIME, 1'b1, 16'hFFFF, 32'hFFFF_FFF0));
		send_word(mk_word(sict_pkg::CMD_TIME, 1'b0, 16'h0, 32'h0000_0020));
		send_word(mk_word(sict_pkg::CMD_TIME, 1'b1, 16'hFFFF, 32'h0000_0022));
		send_word(mk_word(sict_pkg::CMD_CRANK, 1'b0, 16'hFFFF, 32'hAAAA_5555));
		send_word(mk_word(sict_pkg::CMD_CRANK, 1'b1, 16'hFFFF, 32'h5555_AAAA));
		send_word(mk_word(sict_pkg::CMD_TIME, 1'b0, 16'h0, 32'h0000_01E3));
		send_word(mk_word(sict_pkg::CMD_TIME, 1'b0, 16'h0, 32'h0000_01E4));
		send_word(mk_word(sict_pkg::CMD_CRANK, 1'b1, 16'hFFFF, 32'h0));
		send_word(mk_word(sict_pkg::CMD_STOP, 1'b1, 16'hFFFF, 32'hFFFF_FFFF));
		send_word(mk_word(sict_pkg::CMD_TIME, 1'b1, 16'hFFFF, 32'h0));
		send_word(mk_word(sict_pkg::CMD_CRANK, 1'b1, 16'h0, 32'h0));
		// zero lengths end the window in the word that opens it
		apply_settings(1'b1, 16'd0, 16'd0, 16'd0);
		send_word(mk_word(sict_pkg::CMD_CRANK, 1'b1, 16'h0, 32'h0));
		send_word(mk_word(sict_pkg::CMD_TIME, 1'b0, 16'h0, 32'h1234_5678));
		send_word(mk_word(sict_pkg::CMD_CRANK, 1'b1, 16'h0, 32'h0));
		send_word(mk_word(sict_pkg::CMD_CRANK, 1'b1, 16'hFFFF, 32'h0));
		apply_settings(1'b0, 16'd5, 16'd100, 16'd5);
		send_word(mk_word(sict_pkg::CMD_CRANK, 1'b0, 16'hFFFF, 32'h0));
		send_word(mk_word(sict_pkg::CMD_CRANK, 1'b1, 16'hFFFF, 32'h0));
		send_word(mk_word(sict_pkg::CMD_TIME, 1'b1, 16'hFFFF, 32'h8000_0000));
		send_word(mk_word(sict_pkg::CMD_STOP, 1'b0, 16'h0, 32'h0));
	endtask

	task automatic test_random();
		set_idling(10, 51);
		random_phase(1'b1, 16'd10, 16'd3000, 16'd40, 330);
		random_phase(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 330);
		set_idling(51, 10);
		random_phase(1'b1, 16'd0, 16'd0, 16'd0, 330);
		random_phase(1'b0, 16'd5, 16'd100, 16'd5, 300);
		set_idling(0, 0);
		random_phase(1'b1, 16'd30, 16'd1, 16'd10, 330);
	endtask

	task automatic test_result_stall();
		set_idling(0, 0);
		apply_settings(1'b1, 16'd20, 16'd2000, 16'd60);
		clock_ms = $urandom;
		fork
			stall_results(300);
		join_none
		repeat (80) send_word(random_shift_word());
	endtask

	initial begin
		timer_cfg = '{sict_pkg::CutEnableRst, sict_pkg::CutLengthRst, sict_pkg::ArmRpmRst,
			sict_pkg::DeadTimeRst};
		timer_st  = '{1'b1, 1'b0, 1'b0, 1'b0, 32'd0};
		clock_ms  = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		set_idling(10, 51);
		test_registers();
		test_directed();
		test_random();
		test_result_stall();
		drain_results();
		repeat (8) @(posedge clk);
		$display("tb_top: %0d words sent, %0d result words checked, %0d register settings,",
			words_sent, words_checked, settings_used);
		$display("tb_top: idling on each side, one long result stall, %0d mismatches",
			mismatches);
		if (mismatches == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire

[filelist.f]
design/sict_pkg.sv
design/sict_regs.sv
design/sict_core.sv
design/shift_ignition_cut_timer.sv
design/sict_checker.sv
test/tb_top.sv
